/* design/mwc_pkg.sv */
package mwc_pkg;

    // table depths
    localparam int EXACT_SLOTS = 16;
    localparam int RANGE_SLOTS = 8;

    // field widths
    localparam int ADDR_W = 24;
    localparam int SIZE_W = 2;
    localparam int SLOT_W = 4;
    localparam int MODE_W = 3;

    // cell index wide enough for either table and for the slot field
    localparam int MAX_SLOTS  = (EXACT_SLOTS > RANGE_SLOTS) ? EXACT_SLOTS : RANGE_SLOTS;
    localparam int CELL_IDX_W = ($clog2(MAX_SLOTS) > SLOT_W) ? $clog2(MAX_SLOTS) : SLOT_W;

    // total cells in the chain
    localparam int CHAIN_LEN = RANGE_SLOTS + EXACT_SLOTS;

    localparam logic [ADDR_W-1:0] PROTECT_LIMIT = ADDR_W'(24'h000120);

    typedef enum logic [1:0] {
        KIND_CHECK      = 2'd0,
        KIND_LOAD_EXACT = 2'd1,
        KIND_LOAD_RANGE = 2'd2,
        KIND_CLEAR      = 2'd3
    } kind_t;

    typedef enum logic [SIZE_W-1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_WORD = 2'd1,
        SIZE_LONG = 2'd2,
        SIZE_WIDE = 2'd3
    } size_t;

    // request transaction
    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size_code;
        logic              is_write;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] range_top;
        logic              enable;
        logic              protect_on;
    } req_t;

    // response transaction
    typedef struct packed {
        logic              watch_hit;
        logic              hit_is_range;
        logic [SLOT_W-1:0] hit_slot;
        logic [MODE_W-1:0] hit_mode;
        logic              align_error;
        logic              protect_fault;
        logic              pass_to_memory;
    } rsp_t;

    // token handed from cell to cell
    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W:0]   last;
        logic [SIZE_W-1:0] size;
        logic              dir;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] top;
        logic              en;
        logic              prot;
        logic              hit;
        logic              is_range;
        logic [SLOT_W-1:0] hit_idx;
    } token_t;

endpackage

/* design/mwc_range_cell.sv */
module mwc_range_cell
    import mwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic [CELL_IDX_W-1:0] cell_index,
    input  token_t                tok_in,
    output token_t                tok_out
);

    logic              valid_reg, valid_next;
    logic              dir_reg, dir_next;
    logic [ADDR_W-1:0] low_reg, low_next;
    logic [ADDR_W-1:0] high_reg, high_next;
    token_t            tok_reg, tok_next;
    logic              load_me;
    logic              match;

    // entry update and match test
    always_comb
    begin
        valid_next = valid_reg;
        dir_next   = dir_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        tok_next   = tok_in;

        load_me = tok_in.valid && (tok_in.kind == KIND_LOAD_RANGE)
                  && (CELL_IDX_W'(tok_in.slot) == cell_index);
        match   = valid_reg && (dir_reg == tok_in.dir) && (low_reg <= tok_in.addr)
                  && (tok_in.last <= {1'b0, high_reg});

        if (load_me)
        begin
            valid_next = tok_in.en;
            dir_next   = tok_in.dir;
            low_next   = tok_in.addr;
            high_next  = tok_in.top;
        end
        else if (tok_in.valid && (tok_in.kind == KIND_CLEAR))
        begin
            valid_next = 1'b0;
            dir_next   = 1'b0;
            low_next   = '0;
            high_next  = '0;
        end

        // first matching slot wins
        if (tok_in.valid && (tok_in.kind == KIND_CHECK) && !tok_in.hit && match)
        begin
            tok_next.hit      = 1'b1;
            tok_next.is_range = 1'b1;
            tok_next.hit_idx  = cell_index[SLOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dir_reg   <= 1'b0;
            low_reg   <= '0;
            high_reg  <= '0;
            tok_reg   <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
            dir_reg   <= dir_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* design/mwc_exact_cell.sv */
module mwc_exact_cell
    import mwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic [CELL_IDX_W-1:0] cell_index,
    input  token_t                tok_in,
    output token_t                tok_out
);

    logic              valid_reg, valid_next;
    logic              dir_reg, dir_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    token_t            tok_reg, tok_next;
    logic              load_me;
    logic              match;

    // entry update and match test
    always_comb
    begin
        valid_next = valid_reg;
        dir_next   = dir_reg;
        size_next  = size_reg;
        addr_next  = addr_reg;
        tok_next   = tok_in;

        load_me = tok_in.valid && (tok_in.kind == KIND_LOAD_EXACT)
                  && (CELL_IDX_W'(tok_in.slot) == cell_index);
        match   = valid_reg && (dir_reg == tok_in.dir) && (size_reg == tok_in.size)
                  && (addr_reg == tok_in.addr);

        if (load_me)
        begin
            valid_next = tok_in.en;
            dir_next   = tok_in.dir;
            size_next  = tok_in.size;
            addr_next  = tok_in.addr;
        end
        else if (tok_in.valid && (tok_in.kind == KIND_CLEAR))
        begin
            valid_next = 1'b0;
            dir_next   = 1'b0;
            size_next  = '0;
            addr_next  = '0;
        end

        // only if no earlier slot (range or exact) matched
        if (tok_in.valid && (tok_in.kind == KIND_CHECK) && !tok_in.hit && match)
        begin
            tok_next.hit      = 1'b1;
            tok_next.is_range = 1'b0;
            tok_next.hit_idx  = cell_index[SLOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dir_reg   <= 1'b0;
            size_reg  <= '0;
            addr_reg  <= '0;
            tok_reg   <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
            dir_reg   <= dir_next;
            size_reg  <= size_next;
            addr_reg  <= addr_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* design/memory_watchpoint_checker.sv */
// a request passes through every range cell and then every exact cell before its response is valid
// throughput: one transaction per cycle while no response is held; each transaction passes one cell per cycle
// the whole chain holds while a response waits on rsp_stall
// reset: all watch slots invalid and zero, chain empty
module memory_watchpoint_checker
    import mwc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    token_t            chain [CHAIN_LEN+1];
    token_t            head;
    token_t            tail;
    logic              adv;
    logic [SIZE_W-1:0] size_c;
    logic [ADDR_W:0]   span;
    logic              align;
    logic              fault;
    logic              is_check;

    // chain moves unless a finished response is held
    assign adv       = !(rsp_valid && rsp_stall);
    assign req_stall = !adv;

    // form the entry token
    always_comb
    begin
        case (size_t'(req_data.size_code))
            SIZE_BYTE: span = '0;
            SIZE_WORD: span = (ADDR_W+1)'(1);
            SIZE_LONG: span = (ADDR_W+1)'(3);
            SIZE_WIDE: span = (ADDR_W+1)'(3);
            default:   span = (ADDR_W+1)'(3);
        endcase
        size_c = (req_data.size_code == SIZE_WIDE) ? SIZE_LONG : req_data.size_code;

        head.valid    = req_valid;
        head.kind     = kind_t'(req_data.kind);
        head.addr     = req_data.address;
        head.last     = {1'b0, req_data.address} + span;
        head.size     = size_c;
        head.dir      = req_data.is_write;
        head.slot     = req_data.slot;
        head.top      = req_data.range_top;
        head.en       = req_data.enable;
        head.prot     = req_data.protect_on;
        head.hit      = 1'b0;
        head.is_range = 1'b0;
        head.hit_idx  = '0;
    end

    assign chain[0] = head;

    // range cells first so a range hit takes precedence
    for (genvar i = 0; i < RANGE_SLOTS; i++)
    begin : g_range
        mwc_range_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .cell_index (CELL_IDX_W'(i)),
            .tok_in     (chain[i]),
            .tok_out    (chain[i+1])
        );
    end

    for (genvar j = 0; j < EXACT_SLOTS; j++)
    begin : g_exact
        mwc_exact_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .cell_index (CELL_IDX_W'(j)),
            .tok_in     (chain[RANGE_SLOTS+j]),
            .tok_out    (chain[RANGE_SLOTS+j+1])
        );
    end

    assign tail      = chain[CHAIN_LEN];
    assign rsp_valid = tail.valid;

    // response fields from the last cell's token
    always_comb
    begin
        is_check = (tail.kind == KIND_CHECK);
        align    = is_check && (tail.size != SIZE_BYTE) && tail.addr[0];
        fault    = is_check && !align && tail.dir && (tail.addr < PROTECT_LIMIT) && tail.prot;

        rsp_data.watch_hit      = is_check && tail.hit;
        rsp_data.hit_is_range   = is_check && tail.hit && tail.is_range;
        rsp_data.hit_slot       = (is_check && tail.hit) ? tail.hit_idx : '0;
        if (is_check && tail.hit)
        begin
            rsp_data.hit_mode = tail.dir ? (MODE_W'(3) + MODE_W'(tail.size))
                                         : MODE_W'(tail.size);
        end
        else
        begin
            rsp_data.hit_mode = '0;
        end
        rsp_data.align_error    = align;
        rsp_data.protect_fault  = fault;
        rsp_data.pass_to_memory = is_check && !align && !fault;
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
    import mwc_pkg::*;
();

    localparam logic DIR_READ  = 1'b0;
    localparam logic DIR_WRITE = 1'b1;

    localparam int RANDOM_ITEMS = 600;
    localparam int IDLE_PCT     = 18;
    localparam int HOLD_CYCLES  = 90;
    localparam int HOLD_AFTER   = 200;
    localparam int QUIET_FROM   = 350;
    localparam int QUIET_TO     = 450;
    localparam int DRAIN_CYCLES = 2 * CHAIN_LEN + 8;
    localparam int CYCLE_LIMIT  = 200000;

    // watch table entries kept by the predictor
    typedef struct packed {
        bit              valid;
        bit              dir;
        bit [SIZE_W-1:0] size;
        bit [ADDR_W-1:0] addr;
    } exact_watch_t;

    typedef struct packed {
        bit              valid;
        bit              dir;
        bit [ADDR_W-1:0] low;
        bit [ADDR_W-1:0] high;
    } range_watch_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    exact_watch_t exact_watch[EXACT_SLOTS];
    range_watch_t range_watch[RANGE_SLOTS];

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];

    bit req_taken = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int items_sent = 0;
    int results_seen = 0;
    int errors = 0;
    int cycles = 0;

    memory_watchpoint_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic req_t make_req(kind_t k, logic [ADDR_W-1:0] a, size_t s, logic w,
                                      logic [SLOT_W-1:0] sl, logic [ADDR_W-1:0] t,
                                      logic e, logic p);
        req_t r;
        r.kind       = k;
        r.address    = a;
        r.size_code  = s;
        r.is_write   = w;
        r.slot       = sl;
        r.range_top  = t;
        r.enable     = e;
        r.protect_on = p;
        return r;
    endfunction

    // apply one transaction to the watch tables and work out its response
    function automatic rsp_t predict_watch(req_t r);
        rsp_t res;
        logic [SIZE_W-1:0] sz;
        logic [ADDR_W:0] last_byte;
        logic found;
        logic ranged;
        logic [SLOT_W-1:0] idx;
        logic misaligned;
        logic fault;
        res = '0;
        found = 1'b0;
        ranged = 1'b0;
        idx = '0;
        sz = (r.size_code == SIZE_WIDE) ? SIZE_LONG : r.size_code;
        if (r.kind == KIND_LOAD_EXACT)
        begin
            if (r.slot < EXACT_SLOTS)
                exact_watch[r.slot] = '{r.enable, r.is_write, sz, r.address};
        end
        else if (r.kind == KIND_LOAD_RANGE)
        begin
            if (r.slot < RANGE_SLOTS)
                range_watch[r.slot] = '{r.enable, r.is_write, r.address, r.range_top};
        end
        else if (r.kind == KIND_CLEAR)
        begin
            foreach (exact_watch[i])
                exact_watch[i] = '0;
            foreach (range_watch[i])
                range_watch[i] = '0;
        end
        else
        begin
            // last byte touched, no wrap past the top of the address space
            last_byte = {1'b0, r.address}
                      + ((sz == SIZE_BYTE) ? 25'd0 : (sz == SIZE_WORD) ? 25'd1 : 25'd3);
            // range table first, lowest slot wins
            for (int i = 0; i < RANGE_SLOTS; i++)
            begin
                if (!found && range_watch[i].valid && range_watch[i].dir == r.is_write
                    && range_watch[i].low <= r.address
                    && last_byte <= {1'b0, range_watch[i].high})
                begin
                    found = 1'b1;
                    ranged = 1'b1;
                    idx = SLOT_W'(i);
                end
            end
            for (int i = 0; i < EXACT_SLOTS; i++)
            begin
                if (!found && exact_watch[i].valid && exact_watch[i].dir == r.is_write
                    && exact_watch[i].size == sz && exact_watch[i].addr == r.address)
                begin
                    found = 1'b1;
                    idx = SLOT_W'(i);
                end
            end
            misaligned = (sz != SIZE_BYTE) && r.address[0];
            fault = !misaligned && r.is_write && (r.address < PROTECT_LIMIT) && r.protect_on;
            res.watch_hit      = found;
            res.hit_is_range   = ranged;
            res.hit_slot       = found ? idx : '0;
            res.hit_mode       = found ? ((r.is_write ? 3'd3 : 3'd0) + MODE_W'(sz)) : '0;
            res.align_error    = misaligned;
            res.protect_fault  = fault;
            res.pass_to_memory = !misaligned && !fault;
        end
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // request side: predict at the edge that takes the transaction
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
        begin
            expected_rsps.push_back(predict_watch(req_data));
            req_taken = 1'b1;
            items_sent++;
        end
    end

    // request driver: new transaction only once the current one is gone
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_taken))
        begin
            req_taken = 1'b0;
            if (pending_reqs.size() != 0
                && (hold_left != 0
                    || (items_sent >= QUIET_FROM && items_sent < QUIET_TO)
                    || $urandom_range(99) >= IDLE_PCT))
            begin
                req_valid <= 1'b1;
                req_data  <= pending_reqs.pop_front();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response stall: random, one long hold, and a quiet stretch
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    // response monitor and run limit
    always @(posedge clk)
    begin
        rsp_t want;
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("== FAIL ==");
            $finish;
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, got %h", $time, rsp_data);
                errors++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                check_field("watch_hit", want.watch_hit, rsp_data.watch_hit);
                check_field("hit_is_range", want.hit_is_range, rsp_data.hit_is_range);
                check_field("hit_slot", want.hit_slot, rsp_data.hit_slot);
                check_field("hit_mode", want.hit_mode, rsp_data.hit_mode);
                check_field("align_error", want.align_error, rsp_data.align_error);
                check_field("protect_fault", want.protect_fault, rsp_data.protect_fault);
                check_field("pass_to_memory", want.pass_to_memory, rsp_data.pass_to_memory);
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        req_t r;
        req_t ld;
        req_t watch_loads[$];
        int pick;
        int c;

        // directed: empty tables, extremes, precedence, odd and protected accesses
        pending_reqs.push_back(make_req(KIND_CHECK, 24'h000000, SIZE_BYTE, DIR_READ, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(KIND_LOAD_EXACT, 24'h000100, SIZE_WORD, DIR_WRITE,
                                        4'd0, 0, 1, 0));
        pending_reqs.push_back(make_req(KIND_CHECK, 24'h000100, SIZE_WORD, DIR_WRITE, 0, 0, 0, 1));
        pending_reqs.push_back(make_req(KIND_LOAD_EXACT, 24'hFFFFFF, SIZE_BYTE, DIR_READ,
                                        4'd15, 0, 1, 0));
        pending_reqs.push_back(make_req(KIND_CHECK, 24'hFFFFFF, SIZE_BYTE, DIR_READ, 0, 0, 0, 0));
        // disabled slot
        pending_reqs.push_back(make_req(KIND_LOAD_EXACT, 24'h000200, SIZE_LONG, DIR_READ,
                                        4'd3, 0, 0, 0));
        pending_reqs.push_back(make_req(KIND_CHECK, 24'h000200, SIZE_LONG, DIR_READ, 0, 0, 0, 0));
        // size code three stored and checked as long
        pending_reqs.push_back(make_req(KIND_LOAD_EXACT, 24'h000300, SIZE_WIDE, DIR_READ,
                                        4'd5, 0, 1, 0));
        pending_reqs.push_back(make_req(KIND_CHECK, 24'h000300, SIZE_WIDE, DIR_READ, 0, 0, 0, 0));
        // range edges
        pending_reqs.push_back(make_req(KIND_LOAD_RANGE, 24'h001000, SIZE_BYTE, DIR_WRITE,
                                        4'd0, 24'h001FFF, 1, 0));
        pending_reqs.push_back(make_req(KIND_CHECK, 24'h001FFC, SIZE_LONG, DIR_WRITE, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(KIND_CHECK, 24'h001FFE, SIZE_LONG, DIR_WRITE, 0, 0, 0, 0));
        // access running past the top of memory
        pending_reqs.push_back(make_req(KIND_LOAD_RANGE, 24'hFFFFF0, SIZE_BYTE, DIR_READ,
                                        4'd7, 24'hFFFFFF, 1, 0));
        pending_reqs.push_back(make_req(KIND_CHECK, 24'hFFFFFE, SIZE_LONG, DIR_READ, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(KIND_CHECK, 24'hFFFFFF, SIZE_BYTE, DIR_READ, 0, 0, 0, 0));
        // inverted bounds
        pending_reqs.push_back(make_req(KIND_LOAD_RANGE, 24'h005000, SIZE_BYTE, DIR_READ,
                                        4'd2, 24'h004000, 1, 0));
        pending_reqs.push_back(make_req(KIND_CHECK, 24'h004800, SIZE_BYTE, DIR_READ, 0, 0, 0, 0));
        // range wins over exact
        pending_reqs.push_back(make_req(KIND_LOAD_EXACT, 24'h001100, SIZE_WORD, DIR_WRITE,
                                        4'd1, 0, 1, 0));
        pending_reqs.push_back(make_req(KIND_CHECK, 24'h001100, SIZE_WORD, DIR_WRITE, 0, 0, 0, 0));
        // range slot past the table is dropped
        pending_reqs.push_back(make_req(KIND_LOAD_RANGE, 24'h000000, SIZE_BYTE, DIR_READ,
                                        4'd9, 24'hFFFFFF, 1, 0));
        pending_reqs.push_back(make_req(KIND_CHECK, 24'h123456, SIZE_BYTE, DIR_READ, 0, 0, 0, 0));
        // odd address: hit still reported, no protection fault
        pending_reqs.push_back(make_req(KIND_CHECK, 24'h001001, SIZE_WORD, DIR_WRITE, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(KIND_CHECK, 24'h000101, SIZE_WORD, DIR_WRITE, 0, 0, 0, 1));
        // protection boundary
        pending_reqs.push_back(make_req(KIND_CHECK, 24'h00011F, SIZE_BYTE, DIR_WRITE, 0, 0, 0, 1));
        pending_reqs.push_back(make_req(KIND_CHECK, 24'h000120, SIZE_BYTE, DIR_WRITE, 0, 0, 0, 1));
        pending_reqs.push_back(make_req(KIND_CLEAR, 24'h000000, SIZE_BYTE, DIR_READ, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(KIND_CHECK, 24'h001100, SIZE_WORD, DIR_WRITE, 0, 0, 0, 0));

        // random: mostly checks aimed at loaded watches, some loads and clears
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r.kind       = KIND_CHECK;
            r.address    = ADDR_W'($urandom);
            r.range_top  = ADDR_W'($urandom);
            r.size_code  = SIZE_W'($urandom_range(3));
            r.is_write   = 1'($urandom_range(1));
            r.slot       = SLOT_W'($urandom_range(15));
            r.enable     = ($urandom_range(99) < 85);
            r.protect_on = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                r.kind = KIND_LOAD_EXACT;
                if ($urandom_range(1) == 0)
                    r.address = ADDR_W'($urandom_range(16'h01FF));
                watch_loads.push_back(r);
            end
            else if (pick < 18)
            begin
                r.kind = KIND_LOAD_RANGE;
                if ($urandom_range(99) < 75)
                    r.slot = SLOT_W'($urandom_range(RANGE_SLOTS - 1));
                if ($urandom_range(99) < 40)
                    r.address = ADDR_W'($urandom_range(16'h01FF));
                c = $urandom_range(99);
                if (c < 70)
                    r.range_top = r.address + ADDR_W'($urandom_range(255));
                else if (c < 85)
                    r.range_top = r.address - ADDR_W'($urandom_range(1, 64));
                else
                    r.range_top = '1;
                watch_loads.push_back(r);
            end
            else if (pick < 20)
                r.kind = KIND_CLEAR;
            else
            begin
                c = $urandom_range(99);
                if (watch_loads.size() != 0 && c < 60)
                begin
                    ld = watch_loads[$urandom_range(watch_loads.size() - 1)];
                    r.address = ld.address + ADDR_W'($urandom_range(7));
                    if ($urandom_range(99) < 70)
                    begin
                        r.is_write  = ld.is_write;
                        r.size_code = ld.size_code;
                    end
                end
                else if (c < 75)
                    r.address = ADDR_W'($urandom_range(16'h01FF));
            end
            if (watch_loads.size() > 32)
                void'(watch_loads.pop_front());
            pending_reqs.push_back(r);
        end

        // reset
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for every transaction to go in and come back
        while (pending_reqs.size() != 0 || req_valid)
            @(negedge clk);
        while (expected_rsps.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
